### design/refcount_slot_pool_allocator_core_macros.svh
// Assertion macros for the slot pool allocator.
// Used by the datapath; empty bodies when SYNTHESIS is defined.
`ifndef REFCOUNT_SLOT_POOL_ALLOCATOR_CORE_MACROS_SVH
`define REFCOUNT_SLOT_POOL_ALLOCATOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define RSPA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rspa: assertion failed");
`define RSPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rspa: assertion failed");
`else
`define RSPA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RSPA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### design/rspa_pkg.sv
// Shared types and constants for the slot pool allocator.
// No dependencies.
`default_nettype none
package rspa_pkg;

    localparam int MAX_SLOTS = 64;
    localparam int REF_BITS  = 16;
    localparam int SLOT_W    = 6;
    localparam int CNT_W     = 7;
    localparam int OP_W      = 2;
    localparam int ST_W      = 3;

    localparam logic [REF_BITS-1:0] COUNT_MAX = {REF_BITS{1'b1}};

    localparam logic REG_ACTIVE_SLOTS = 1'b0;
    localparam logic [CNT_W-1:0] ACTIVE_RESET = CNT_W'(MAX_SLOTS);

    typedef enum logic [OP_W-1:0] {
        OP_ACQUIRE = 2'd0,
        OP_ADD_REF = 2'd1,
        OP_RELEASE = 2'd2,
        OP_NOP     = 2'd3
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 3'd0,
        ST_NO_FREE   = 3'd1,
        ST_NOT_HELD  = 3'd2,
        ST_OVERFLOW  = 3'd3,
        ST_BAD_INDEX = 3'd4
    } status_t;

    typedef enum logic {
        CS_IDLE,
        CS_EXEC
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic exec;
    } dp_cmd_t;

endpackage
`default_nettype wire

### design/rspa_ctrl.sv
// Controller for the slot pool allocator: sequences capture and update.
// Depends on rspa_pkg.
`default_nettype none
module rspa_ctrl (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               start,
    output logic              busy,
    output logic              done,
    output rspa_pkg::dp_cmd_t cmd
);
    import rspa_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= cmd.exec;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.exec   = 1'b0;
        busy       = 1'b0;
        unique case (state_reg)
            CS_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = CS_EXEC;
                end
            end
            CS_EXEC:
            begin
                busy       = 1'b1;
                cmd.exec   = 1'b1;
                state_next = CS_IDLE;
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    assign done = done_reg;

endmodule
`default_nettype wire

### design/rspa_datapath.sv
// Datapath for the slot pool allocator: count memory, held bitmap,
// lowest-free encoder, in-use and peak counters, result registers.
// Depends on rspa_pkg and the assertion macro header.
`default_nettype none
`include "refcount_slot_pool_allocator_core_macros.svh"
module rspa_datapath (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire rspa_pkg::dp_cmd_t       cmd,
    input  wire [rspa_pkg::CNT_W-1:0]    active_slots,
    input  wire [rspa_pkg::OP_W-1:0]     opcode,
    input  wire [rspa_pkg::SLOT_W-1:0]   slot_index,
    output logic [rspa_pkg::ST_W-1:0]    status,
    output logic [rspa_pkg::SLOT_W-1:0]  granted_slot,
    output logic                         slot_freed,
    output logic [rspa_pkg::CNT_W-1:0]   slots_in_use,
    output logic [rspa_pkg::CNT_W-1:0]   peak_in_use
);
    import rspa_pkg::*;

    logic [REF_BITS-1:0] count_mem [MAX_SLOTS];

    op_t                 op_reg;
    logic [SLOT_W-1:0]   idx_reg;
    logic [REF_BITS-1:0] rd_data_reg;
    logic [MAX_SLOTS-1:0] held_reg;
    logic [MAX_SLOTS-1:0] held_next;
    logic [CNT_W-1:0]    in_use_reg;
    logic [CNT_W-1:0]    in_use_next;
    logic [CNT_W-1:0]    peak_reg;
    logic [CNT_W-1:0]    peak_next;
    status_t             status_reg;
    status_t             status_next;
    logic [SLOT_W-1:0]   slot_reg;
    logic [SLOT_W-1:0]   slot_next;
    logic                freed_reg;
    logic                freed_next;

    logic [CNT_W-1:0]     limit;
    logic [MAX_SLOTS-1:0] free_mask;
    logic                 free_found;
    logic [SLOT_W-1:0]    free_slot;
    logic [REF_BITS-1:0]  cur_count;
    logic                 wr_en;
    logic [SLOT_W-1:0]    wr_addr;
    logic [REF_BITS-1:0]  wr_data;

    // Active slot count saturates at the pool size.
    assign limit = (active_slots > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : active_slots;

    always_comb
    begin
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            free_mask[i] = !held_reg[i] && (CNT_W'(i) < limit);
        end
    end

    // Lowest-numbered free slot.
    always_comb
    begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = MAX_SLOTS - 1; i >= 0; i--)
        begin
            if (free_mask[i])
            begin
                free_found = 1'b1;
                free_slot  = SLOT_W'(i);
            end
        end
    end

    // An unheld slot reads as zero whatever the memory holds.
    assign cur_count = held_reg[idx_reg] ? rd_data_reg : '0;

    always_comb
    begin
        held_next   = held_reg;
        in_use_next = in_use_reg;
        peak_next   = peak_reg;
        status_next = ST_OK;
        slot_next   = idx_reg;
        freed_next  = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = idx_reg;
        wr_data     = '0;
        unique case (op_reg)
            OP_ACQUIRE:
            begin
                if (free_found)
                begin
                    slot_next            = free_slot;
                    wr_en                = 1'b1;
                    wr_addr              = free_slot;
                    wr_data              = REF_BITS'(1);
                    held_next[free_slot] = 1'b1;
                    in_use_next          = in_use_reg + CNT_W'(1);
                    if (in_use_next > peak_reg)
                    begin
                        peak_next = in_use_next;
                    end
                end
                else
                begin
                    status_next = ST_NO_FREE;
                    slot_next   = '0;
                end
            end
            OP_ADD_REF, OP_RELEASE:
            begin
                priority if (CNT_W'(idx_reg) >= limit)
                begin
                    status_next = ST_BAD_INDEX;
                end
                else if (cur_count == '0)
                begin
                    status_next = ST_NOT_HELD;
                end
                else if (op_reg == OP_ADD_REF)
                begin
                    if (cur_count == COUNT_MAX)
                    begin
                        status_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        wr_en   = 1'b1;
                        wr_data = cur_count + REF_BITS'(1);
                    end
                end
                else
                begin
                    wr_en   = 1'b1;
                    wr_data = cur_count - REF_BITS'(1);
                    if (cur_count == REF_BITS'(1))
                    begin
                        freed_next         = 1'b1;
                        held_next[idx_reg] = 1'b0;
                        if (in_use_reg != '0)
                        begin
                            in_use_next = in_use_reg - CNT_W'(1);
                        end
                    end
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rd_data_reg <= count_mem[slot_index];
        end
        if (cmd.exec && wr_en)
        begin
            count_mem[wr_addr] <= wr_data;
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= op_t'(opcode);
            idx_reg <= slot_index;
        end
        if (cmd.exec)
        begin
            status_reg <= status_next;
            slot_reg   <= slot_next;
            freed_reg  <= freed_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg   <= '0;
            in_use_reg <= '0;
            peak_reg   <= '0;
        end
        else if (cmd.exec)
        begin
            held_reg   <= held_next;
            in_use_reg <= in_use_next;
            peak_reg   <= peak_next;
        end
    end

    assign status       = status_reg;
    assign granted_slot = slot_reg;
    assign slot_freed   = freed_reg;
    assign slots_in_use = in_use_reg;
    assign peak_in_use  = peak_reg;

    `RSPA_ASSERT_IMPL(a_inuse_matches_held, clk, rst_n, 1'b1,
                      CNT_W'($countones(held_reg)) == in_use_reg)
    `RSPA_ASSERT_IMPL(a_peak_covers_inuse, clk, rst_n, 1'b1, peak_reg >= in_use_reg)
    `RSPA_ASSERT_NEXT(a_idle_holds_state, clk, rst_n, !cmd.exec,
                      $stable(held_reg) && $stable(peak_reg))
    `RSPA_ASSERT_IMPL(a_freed_only_ok, clk, rst_n, cmd.exec && freed_next,
                      status_next == ST_OK && op_reg == OP_RELEASE)

endmodule
`default_nettype wire

### design/refcount_slot_pool_allocator_core.sv
// Reference-counted slot pool allocator. Takes one command word when start is
// high and busy is low, and delivers one result word, marked by a one-cycle
// done strobe that the receiver cannot hold off. Each command first reads the
// slot's count from the single-port count memory, then updates it and
// registers the result; busy is low again while done is high, so a new command
// is taken only once the last one's result is registered. Reset clears all
// counts at once through a per-slot held bitmap; no clearing pass is needed.
// Depends on rspa_pkg, rspa_ctrl and rspa_datapath.
`default_nettype none
module refcount_slot_pool_allocator_core (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [2:0]                   paddr,
    input  wire  [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  wire                          start,
    output logic                         busy,
    input  wire  [rspa_pkg::OP_W-1:0]    opcode,
    input  wire  [rspa_pkg::SLOT_W-1:0]  slot_index,
    output logic                         done,
    output logic [rspa_pkg::ST_W-1:0]    status,
    output logic [rspa_pkg::SLOT_W-1:0]  granted_slot,
    output logic                         slot_freed,
    output logic [rspa_pkg::CNT_W-1:0]   slots_in_use,
    output logic [rspa_pkg::CNT_W-1:0]   peak_in_use
);
    import rspa_pkg::*;

    logic [CNT_W-1:0] active_reg;
    logic             reg_sel;
    logic             cfg_write;
    dp_cmd_t          cmd;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ACTIVE_RESET;
        end
        else if (cfg_write && (reg_sel == REG_ACTIVE_SLOTS))
        begin
            active_reg <= pwdata[CNT_W-1:0];
        end
    end

    assign prdata = (reg_sel == REG_ACTIVE_SLOTS) ? {{(32 - CNT_W){1'b0}}, active_reg} : '0;

    rspa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    rspa_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .active_slots (active_reg),
        .opcode       (opcode),
        .slot_index   (slot_index),
        .status       (status),
        .granted_slot (granted_slot),
        .slot_freed   (slot_freed),
        .slots_in_use (slots_in_use),
        .peak_in_use  (peak_in_use)
    );

endmodule
`default_nettype wire
